// ===== sv/assert_macros.svh =====
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== sv/fpie_pkg.sv =====
// ----------------------------------------------------------------------------
// fpie_pkg
// types, constants and command structs for the integer power block
// ----------------------------------------------------------------------------
package fpie_pkg;

  localparam int unsigned ExpW = 32;
  localparam int unsigned CntW = $clog2(ExpW + 1);

  localparam logic [63:0] FpOne    = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] FpNegOne = 64'hBFF0_0000_0000_0000;
  localparam logic [63:0] FpZero   = 64'h0;
  localparam logic [63:0] FpDefNan = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] FpQuiet  = 64'h0008_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1
  } fop_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RECIP,
    ST_RECIP_WAIT,
    ST_BIT,
    ST_MUL_WAIT,
    ST_SQR,
    ST_SQR_WAIT,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_DIV, F_NORM, F_RND, F_DONE
  } fst_e;

  typedef enum logic [1:0] {
    SEL_ACC,
    SEL_BASE
  } wsel_e;

  typedef struct packed {
    logic  load;
    logic  fu_start;
    fop_e  fu_op;
    logic  fu_a_one;
    logic  fu_b_base;
    logic  wr_en;
    wsel_e wr_sel;
    logic  shift;
    logic  set_special;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic negative;
    logic mag_zero;
    logic mag_lsb;
    logic fu_done;
  } sts_t;

endpackage

// ===== sv/float_power_integer_exponent.sv =====
// ----------------------------------------------------------------------------
// float_power_integer_exponent
// binary64 base raised to a signed integer power by square and multiply
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o with base_bits_i and exponent_i
// output channel: out_valid_o / out_stall_i with power_bits_o
// one item in flight; a new beat is taken only once the result beat left
// each exponent bit takes a square in the shared fpu, and a set bit adds a
// multiply before it; a negative exponent adds a divide for the reciprocal
// special bases skip the fpu; the longest run is for a negative
// exponent with 31 set bits; the next beat is taken in the cycle after the result
// the single shared multiply/divide unit sets the rate
// the result beat holds stable while out_stall_i is high
// reset empties the block; no beat is pending after it
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module float_power_integer_exponent (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [63:0]               base_bits_i,
  input  logic [fpie_pkg::ExpW-1:0] exponent_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [63:0]               power_bits_o
);
  import fpie_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  state_e st;

  fpie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts),
    .state_o    (st)
  );

  fpie_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .base_bits_i (base_bits_i),
    .exponent_i  (exponent_i),
    .power_bits_o(power_bits_o)
  );

  `ASSERT_NEVER(a_busy_both, clk_i, rst_ni, (!in_stall_o && out_valid_o))
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i |=> $stable(power_bits_o)))
  `ASSERT_NEVER(a_wr_no_load, clk_i, rst_ni, (cmd.load && cmd.wr_en))
  `ASSERT_NEVER(a_out_state, clk_i, rst_ni, (out_valid_o && (st != ST_OUT)))

endmodule

// ===== sv/fpie_fpu.sv =====
// ----------------------------------------------------------------------------
// fpie_fpu
// multicycle binary64 multiply and divide, round to nearest even
// ----------------------------------------------------------------------------
module fpie_fpu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  fpie_pkg::fop_e     op_i,
  input  logic [63:0]        a_i,
  input  logic [63:0]        b_i,
  output logic               done_o,
  output logic [63:0]        res_o
);
  import fpie_pkg::*;

  fst_e        st_q, st_d;
  logic        sgn_q;
  logic signed [13:0] exp_q;
  logic [52:0] ma_q, mb_q;
  logic [107:0] prod_q;
  logic [5:0]  step_q;
  logic [56:0] rem_q;
  logic [56:0] quo_q;
  logic [63:0] res_q;
  logic        spec_q;
  logic [63:0] spec_val_q;
  logic        is_div_q;
  logic [26:0]  pa_s, pb_s;
  logic [53:0]  pp;
  logic [107:0] pp_sh;
  logic [56:0]  rsub;

  logic        sa, sb;
  logic [10:0] ea, eb;
  logic [51:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [52:0] ma_n, mb_n;
  logic [5:0]  lza, lzb;
  logic signed [13:0] ea_n, eb_n;

  function automatic logic [5:0] lz53(input logic [52:0] v);
    logic [5:0] n;
    logic       f;
    n = 6'd0;
    f = 1'b0;
    for (int i = 52; i >= 0; i--) begin
      if (!f && v[i]) begin
        f = 1'b1;
      end else if (!f) begin
        n = n + 6'd1;
      end
    end
    return n;
  endfunction

  always_comb begin
    sa = a_i[63]; ea = a_i[62:52]; fa = a_i[51:0];
    sb = b_i[63]; eb = b_i[62:52]; fb = b_i[51:0];
    a_nan = (ea == 11'h7FF) && (fa != 52'd0);
    b_nan = (eb == 11'h7FF) && (fb != 52'd0);
    a_inf = (ea == 11'h7FF) && (fa == 52'd0);
    b_inf = (eb == 11'h7FF) && (fb == 52'd0);
    a_zero = (ea == 11'd0) && (fa == 52'd0);
    b_zero = (eb == 11'd0) && (fb == 52'd0);
    lza = lz53({(ea != 11'd0), fa});
    lzb = lz53({(eb != 11'd0), fb});
    ma_n = {(ea != 11'd0), fa} << lza;
    mb_n = {(eb != 11'd0), fb} << lzb;
    ea_n = $signed({3'd0, ((ea == 11'd0) ? 11'd1 : ea)}) - $signed({8'd0, lza});
    eb_n = $signed({3'd0, ((eb == 11'd0) ? 11'd1 : eb)}) - $signed({8'd0, lzb});
  end

  // product of two 53-bit mantissas, one 27 by 27 bit partial product per cycle
  assign pa_s = step_q[0] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
  assign pb_s = step_q[1] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
  assign pp   = {27'd0, pa_s} * {27'd0, pb_s};
  assign rsub = rem_q - {4'd0, mb_q};

  always_comb begin
    case (step_q[1:0])
      2'd0:       pp_sh = {54'd0, pp};
      2'd1, 2'd2: pp_sh = {27'd0, pp, 27'd0};
      default:    pp_sh = {pp, 54'd0};
    endcase
  end

  // rounding of a normalized 57-bit significand (1.52 + guard bits + sticky)
  logic [56:0] nsig;
  logic signed [13:0] nexp;
  logic [5:0]  dsh;
  logic [56:0] dsig;
  logic [53:0] rsig;
  logic        lsb, grd, stk;
  logic [63:0] packed_res;
  logic [11:0] eout;

  always_comb begin
    nsig = quo_q;
    nexp = exp_q;
    dsh = 6'd0;
    if (nexp < 14'sd1) begin
      dsh = ((14'sd1 - nexp) > 14'sd56) ? 6'd56 : 6'(14'sd1 - nexp);
    end
    dsig = (nsig >> dsh) | {56'd0, ((nsig & ((57'd1 << dsh) - 57'd1)) != 57'd0)};
    lsb = dsig[4];
    grd = dsig[3];
    stk = |dsig[2:0];
    rsig = {1'b0, dsig[56:4]} + {53'd0, (grd && (stk || lsb))};
    eout = (nexp < 14'sd1) ? 12'd0 : nexp[11:0];
    if (rsig[53]) begin
      rsig = rsig >> 1;
      eout = eout + 12'd1;
    end else if (eout == 12'd0 && rsig[52]) begin
      eout = 12'd1;
    end
    if (eout >= 12'd2047) begin
      packed_res = {sgn_q, 11'h7FF, 52'd0};
    end else begin
      packed_res = {sgn_q, eout[10:0], rsig[51:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      F_IDLE: if (start_i) st_d = F_MUL;
      F_MUL: begin
        if (spec_q) st_d = F_DONE;
        else if (is_div_q) st_d = F_DIV;
        else if (step_q == 6'd3) st_d = F_NORM;
      end
      F_DIV:  if (step_q == 6'd55) st_d = F_NORM;
      F_NORM: st_d = F_RND;
      F_RND:  st_d = F_DONE;
      F_DONE: st_d = F_IDLE;
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      F_IDLE: begin
        if (start_i) begin
          is_div_q <= (op_i == OP_DIV);
          sgn_q <= sa ^ sb;
          ma_q <= ma_n;
          mb_q <= mb_n;
          prod_q <= '0;
          step_q <= 6'd0;
          spec_q <= 1'b1;
          if (op_i == OP_MUL) begin
            exp_q <= ea_n + eb_n - 14'sd1023;
            if (a_nan) spec_val_q <= a_i | FpQuiet;
            else if (b_nan) spec_val_q <= b_i | FpQuiet;
            else if ((a_inf && b_zero) || (a_zero && b_inf)) spec_val_q <= FpDefNan;
            else if (a_inf || b_inf) spec_val_q <= {sa ^ sb, 11'h7FF, 52'd0};
            else if (a_zero || b_zero) spec_val_q <= {sa ^ sb, 63'd0};
            else spec_q <= 1'b0;
          end else begin
            exp_q <= ea_n - eb_n + 14'sd1023;
            rem_q <= {4'd0, ma_n};
            quo_q <= '0;
            if (a_nan) spec_val_q <= a_i | FpQuiet;
            else if (b_nan) spec_val_q <= b_i | FpQuiet;
            else if ((a_inf && b_inf) || (a_zero && b_zero)) spec_val_q <= FpDefNan;
            else if (a_inf || b_zero) spec_val_q <= {sa ^ sb, 11'h7FF, 52'd0};
            else if (a_zero || b_inf) spec_val_q <= {sa ^ sb, 63'd0};
            else spec_q <= 1'b0;
          end
        end
      end
      F_MUL: begin
        if (!is_div_q) begin
          if (step_q == 6'd0) prod_q <= pp_sh;
          else prod_q <= prod_q + pp_sh;
          step_q <= step_q + 6'd1;
        end
      end
      F_DIV: begin
        if (!rsub[56]) begin
          rem_q <= (rsub << 1);
          quo_q <= {quo_q[55:0], 1'b1};
        end else begin
          rem_q <= (rem_q << 1);
          quo_q <= {quo_q[55:0], 1'b0};
        end
        step_q <= step_q + 6'd1;
      end
      F_NORM: begin
        if (is_div_q) begin
          // quotient in [0.5,2): 56 bits developed plus sticky
          if (quo_q[55]) begin
            quo_q <= {quo_q[55:0], 1'b0} | {56'd0, (rem_q != 57'd0)};
          end else begin
            quo_q <= {quo_q[54:0], 2'b00} | {56'd0, (rem_q != 57'd0)};
            exp_q <= exp_q - 14'sd1;
          end
        end else begin
          if (prod_q[105]) begin
            quo_q <= {prod_q[105:50], (prod_q[49:0] != 50'd0)};
            exp_q <= exp_q + 14'sd1;
          end else begin
            quo_q <= {prod_q[104:49], (prod_q[48:0] != 49'd0)};
          end
        end
      end
      F_RND: res_q <= packed_res;
      F_DONE: if (spec_q) res_q <= spec_val_q;
      default: ;
    endcase
  end

  assign done_o = (st_q == F_DONE);
  assign res_o  = spec_q ? spec_val_q : res_q;

endmodule

// ===== sv/fpie_dp.sv =====
// ----------------------------------------------------------------------------
// fpie_dp
// datapath: operand registers, exponent shifter and the shared fpu
// ----------------------------------------------------------------------------
module fpie_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fpie_pkg::cmd_t          cmd_i,
  output fpie_pkg::sts_t          sts_o,
  input  logic [63:0]             base_bits_i,
  input  logic [fpie_pkg::ExpW-1:0] exponent_i,
  output logic [63:0]             power_bits_o
);
  import fpie_pkg::*;

  logic [63:0]     base_q, acc_q, spec_q;
  logic [ExpW-1:0] mag_q;
  logic            neg_q, special_q;
  logic [63:0]     fa, fb, fres;
  logic            fdone;
  logic            bz, bone, bneg1;

  assign bone  = (base_bits_i == FpOne);
  assign bneg1 = (base_bits_i == FpNegOne);
  assign bz    = (base_bits_i[62:0] == 63'd0);

  assign fa = cmd_i.fu_a_one ? FpOne : (cmd_i.fu_b_base ? base_q : acc_q);
  assign fb = base_q;

  fpie_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.fu_start),
    .op_i   (cmd_i.fu_op),
    .a_i    (fa),
    .b_i    (fb),
    .done_o (fdone),
    .res_o  (fres)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_bits_i;
      neg_q  <= exponent_i[ExpW-1];
      mag_q  <= exponent_i[ExpW-1] ? (~exponent_i + ExpW'(1)) : exponent_i;
      acc_q  <= FpOne;
      special_q <= (exponent_i == '0) || bone || bz || bneg1;
      if (exponent_i == '0 || bone) spec_q <= FpOne;
      else if (bz) spec_q <= FpZero;
      else spec_q <= exponent_i[0] ? FpNegOne : FpOne;
    end else begin
      if (cmd_i.wr_en) begin
        if (cmd_i.wr_sel == SEL_ACC) acc_q <= fres;
        else base_q <= fres;
      end
      if (cmd_i.shift) mag_q <= mag_q >> 1;
      if (cmd_i.set_special) acc_q <= spec_q;
    end
  end

  assign sts_o.special  = special_q;
  assign sts_o.negative = neg_q;
  assign sts_o.mag_zero = (mag_q == '0);
  assign sts_o.mag_lsb  = mag_q[0];
  assign sts_o.fu_done  = fdone;
  assign power_bits_o   = acc_q;

endmodule

// ===== sv/fpie_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpie_ctrl
// sequencer for reciprocal, multiply and square steps
// ----------------------------------------------------------------------------
module fpie_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fpie_pkg::cmd_t cmd_o,
  input  fpie_pkg::sts_t sts_i,
  output fpie_pkg::state_e state_o
);
  import fpie_pkg::*;

  state_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    cmd_o = '0;
    cmd_o.fu_op = OP_MUL;
    cmd_o.wr_sel = SEL_ACC;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    case (st_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          st_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.special) begin
          cmd_o.set_special = 1'b1;
          st_d = ST_OUT;
        end else if (sts_i.negative) begin
          st_d = ST_RECIP;
        end else begin
          st_d = ST_BIT;
        end
      end
      ST_RECIP: begin
        cmd_o.fu_start = 1'b1;
        cmd_o.fu_op = OP_DIV;
        cmd_o.fu_a_one = 1'b1;
        st_d = ST_RECIP_WAIT;
      end
      ST_RECIP_WAIT: begin
        if (sts_i.fu_done) begin
          cmd_o.wr_en = 1'b1;
          cmd_o.wr_sel = SEL_BASE;
          st_d = ST_BIT;
        end
      end
      ST_BIT: begin
        if (sts_i.mag_zero) begin
          st_d = ST_OUT;
        end else if (sts_i.mag_lsb) begin
          cmd_o.fu_start = 1'b1;
          st_d = ST_MUL_WAIT;
        end else begin
          st_d = ST_SQR;
        end
      end
      ST_MUL_WAIT: begin
        if (sts_i.fu_done) begin
          cmd_o.wr_en = 1'b1;
          st_d = ST_SQR;
        end
      end
      ST_SQR: begin
        cmd_o.fu_start = 1'b1;
        cmd_o.fu_b_base = 1'b1;
        st_d = ST_SQR_WAIT;
      end
      ST_SQR_WAIT: begin
        if (sts_i.fu_done) begin
          cmd_o.wr_en = 1'b1;
          cmd_o.wr_sel = SEL_BASE;
          cmd_o.shift = 1'b1;
          st_d = ST_BIT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign state_o = st_q;

endmodule

// ===== verif/float_power_integer_exponent_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// float_power_integer_exponent_tb
// checks binary64 integer powers against a square-and-multiply predictor
// built on host double arithmetic; directed special cases, then random
// bases and exponents under three phases of random idling and stalling
// ----------------------------------------------------------------------------
module float_power_integer_exponent_tb;

  localparam int unsigned EW = fpie_pkg::ExpW;

  typedef struct packed {
    logic [63:0]   base_bits;
    logic [EW-1:0] exponent;
  } pow_item_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic [63:0]   base_bits_i = '0;
  logic [EW-1:0] exponent_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [63:0]   power_bits_o;

  pow_item_t   pending_items[$];
  logic [63:0] expected_powers[$];
  int          error_count = 0;
  int          items_sent = 0;
  int          sender_idle_pct = 24;
  int          receiver_stall_pct = 52;
  bit          beat_taken = 1'b0;
  bit          drain_done = 1'b0;

  float_power_integer_exponent dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .base_bits_i  (base_bits_i),
    .exponent_i   (exponent_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .power_bits_o (power_bits_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [63:0] int_power_bits(logic [63:0] base_bits, logic [EW-1:0] raw);
    real         base;
    real         acc;
    logic [EW-1:0] mag;
    base = $bitstoreal(base_bits);
    acc = 1.0;
    if (raw == '0 || base == 1.0) return fpie_pkg::FpOne;
    if (base == 0.0) return fpie_pkg::FpZero;
    if (base == -1.0) return raw[0] ? fpie_pkg::FpNegOne : fpie_pkg::FpOne;
    if (raw[EW-1]) begin
      mag = -raw;
      base = 1.0 / base;
    end else begin
      mag = raw;
    end
    while (mag != '0) begin
      if (mag[0]) acc = acc * base;
      base = base * base;
      mag = mag >> 1;
    end
    return $realtobits(acc);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic queue_item(logic [63:0] b, logic [EW-1:0] e);
    pow_item_t it;
    it.base_bits = b;
    it.exponent = e;
    pending_items.push_back(it);
  endtask

  function automatic logic [63:0] random_base();
    logic [63:0] b;
    b = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0, 1: b[62:52] = 11'h3FF - 11'($urandom_range(0, 2));
      2: b[62:52] = 11'($urandom_range(11'h3F0, 11'h40F));
      3: b[51:20] = '0;
      default: ;
    endcase
    return b;
  endfunction

  function automatic logic [EW-1:0] random_exponent();
    logic [EW-1:0] e;
    case ($urandom_range(0, 7))
      0: e = EW'($urandom);
      1: e = {EW{1'b1}} << $urandom_range(0, EW - 1);
      2, 3: e = EW'($urandom_range(0, 64)) * ($urandom_range(0, 1) ? -1 : 1);
      default: e = EW'($urandom_range(0, 3000)) * ($urandom_range(0, 1) ? -1 : 1);
    endcase
    return e;
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || beat_taken) begin
        if (items_sent == 300 && !drain_done) begin
          if (expected_powers.size() == 0) drain_done = 1'b1;
        end
        if (items_sent > 217) begin
          sender_idle_pct = 52;
          receiver_stall_pct = 24;
        end
        if (items_sent > 434) begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        if (pending_items.size() != 0 && (drain_done || items_sent != 300)
            && $urandom_range(0, 99) >= sender_idle_pct) begin
          base_bits_i <= pending_items[0].base_bits;
          exponent_i <= pending_items[0].exponent;
          in_valid_i <= 1'b1;
          void'(pending_items.pop_front());
          items_sent++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    beat_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_powers.push_back(int_power_bits(base_bits_i, exponent_i));
        beat_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_powers.size() == 0) begin
          report_mismatch("unexpected beat", power_bits_o, '0);
        end else begin
          if (power_bits_o !== expected_powers[0])
            report_mismatch("power_bits", power_bits_o, expected_powers[0]);
          void'(expected_powers.pop_front());
        end
      end
    end
  end

  initial begin
    logic [EW-1:0] min_exp;
    min_exp = '0;
    min_exp[EW-1] = 1'b1;
    queue_item(64'h4000_0000_0000_0000, '0);
    queue_item(64'h3FF0_0000_0000_0000, min_exp);
    queue_item(64'h0000_0000_0000_0000, 3);
    queue_item(64'h8000_0000_0000_0000, -5);
    queue_item(64'hBFF0_0000_0000_0000, 7);
    queue_item(64'hBFF0_0000_0000_0000, -4);
    queue_item(64'h7FF8_0000_0000_0001, 2);
    queue_item(64'hFFFF_FFFF_FFFF_FFFF, -1);
    queue_item(64'h7FF0_0000_0000_0000, -1);
    queue_item(64'hFFF0_0000_0000_0000, 3);
    queue_item(64'h3FF0_0000_0000_0001, min_exp);
    queue_item(64'h3FEF_FFFF_FFFF_FFFF, ~min_exp);
    queue_item(64'h4000_0000_0000_0000, 2000);
    queue_item(64'h4000_0000_0000_0000, -1074);
    queue_item(64'h4000_0000_0000_0000, -1080);
    queue_item(64'h0000_0000_0000_0001, 1);
    queue_item(64'h0000_0000_0000_0001, -1);
    queue_item(64'h000F_FFFF_FFFF_FFFF, 2);
    queue_item(64'h7FEF_FFFF_FFFF_FFFF, -1);
    queue_item(64'hC008_0000_0000_0000, 13);
    queue_item(64'h3FF8_0000_0000_0000, -37);
    repeat (630) queue_item(random_base(), random_exponent());
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_items.size() == 0);
    @(posedge clk_i);
    while (in_valid_i || expected_powers.size() != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    if (error_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/fpie_pkg.sv
sv/fpie_fpu.sv
sv/fpie_dp.sv
sv/fpie_ctrl.sv
sv/float_power_integer_exponent.sv
verif/float_power_integer_exponent_tb.sv
